>>> rtl/core/assert_macros.svh
// Assertion macros for the ALU core RTL.
// Depends on nothing; files that assert include it by name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define PALU_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PALU_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    `PALU_ASSERT(label, clk, rst_n, (ante) |-> (cons), msg)
`else
`define PALU_ASSERT(label, clk, rst_n, prop, msg)
`define PALU_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> rtl/core/palu_pkg.sv
// Package for the pcode ALU core: transaction structs, opcodes and pipeline record.
// Depends on nothing.
`default_nettype none
package palu_pkg;

    localparam int unsigned VAL_W = 64;

    typedef struct packed {
        logic [4:0]       func;
        logic [VAL_W-1:0] a_value;
        logic             a_defined;
        logic [VAL_W-1:0] b_value;
        logic             b_defined;
        logic [3:0]       a_bytes;
        logic [3:0]       b_bytes;
        logic [3:0]       out_bytes;
    } t_in_item;

    typedef struct packed {
        logic [VAL_W-1:0] result;
        logic             result_defined;
    } t_out_item;

    typedef enum logic [4:0] {
        OP_COPY     = 5'd0,
        OP_EQ       = 5'd1,
        OP_NE       = 5'd2,
        OP_LTU      = 5'd3,
        OP_LTS      = 5'd4,
        OP_LEU      = 5'd5,
        OP_LES      = 5'd6,
        OP_ZEXT     = 5'd7,
        OP_SEXT     = 5'd8,
        OP_ADD      = 5'd9,
        OP_SUB      = 5'd10,
        OP_NOT      = 5'd11,
        OP_XOR      = 5'd12,
        OP_AND      = 5'd13,
        OP_OR       = 5'd14,
        OP_SHL      = 5'd15,
        OP_SHR      = 5'd16,
        OP_SAR      = 5'd17,
        OP_MUL      = 5'd18,
        OP_DIVU     = 5'd19,
        OP_DIVS     = 5'd20,
        OP_REMU     = 5'd21,
        OP_REMS     = 5'd22,
        OP_BNOT     = 5'd23,
        OP_BXOR     = 5'd24,
        OP_BAND     = 5'd25,
        OP_BOR      = 5'd26,
        OP_PIECE    = 5'd27,
        OP_SUBPIECE = 5'd28
    } t_op;

    typedef enum logic [1:0] {
        K_SIMPLE = 2'd0,
        K_DIV    = 2'd1,
        K_REM    = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind            kind;
        logic             def;
        logic             negr;
        logic [VAL_W-1:0] res;
        logic [VAL_W-1:0] omask;
        logic [VAL_W-1:0] dd;
        logic [VAL_W-1:0] dv;
        logic [VAL_W-1:0] q;
        logic [VAL_W-1:0] rm;
    } t_pipe;

endpackage
`default_nettype wire

>>> rtl/core/pcode_op_alu_core.sv
// Top level of the pcode integer ALU: front stages, divider chain and output stage.
// Depends on palu_pkg, palu_front, palu_div_step and assert_macros.svh.
//
// Executes one integer, boolean or bit operation per transaction and accepts a new
// transaction every cycle while the output is not held. Each transaction passes through
// three front stages (operand prep, decode and multiply partial products,
// multiply sum), DATA_WIDTH restoring-divider stages that each resolve one quotient
// bit, and the output register. Every operation runs through the full chain, so
// results leave in input order. When the output is held, the whole pipeline holds
// and the input is not ready.
`default_nettype none
`include "assert_macros.svh"
module pcode_op_alu_core
    import palu_pkg::*;
#(
    parameter int unsigned DATA_WIDTH = 64
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_valid,
    output logic           o_ready,
    input  wire t_in_item  i_data,
    output logic           o_valid,
    input  wire logic      i_ready,
    output t_out_item      o_data
);

    logic                en;
    logic  [DATA_WIDTH:0] w_vld;
    t_pipe                w_pipe [DATA_WIDTH+1];
    t_pipe                fin;
    logic [VAL_W-1:0]     res;
    logic                 r_out_valid;
    t_out_item            r_out_data, n_out_data;

    assign en      = !r_out_valid || i_ready;
    assign o_ready = en;

    palu_front #(
        .DATA_WIDTH(DATA_WIDTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_data  (i_data),
        .o_valid (w_vld[0]),
        .o_pipe  (w_pipe[0])
    );

    for (genvar k = 0; k < DATA_WIDTH; k++) begin : g_div
        palu_div_step #(
            .BIT(DATA_WIDTH - 1 - k)
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (w_vld[k]),
            .i_pipe  (w_pipe[k]),
            .o_valid (w_vld[k+1]),
            .o_pipe  (w_pipe[k+1])
        );
    end

    always_comb begin
        fin = w_pipe[DATA_WIDTH];
        case (fin.kind)
            K_DIV:   res = fin.negr ? (~fin.q + VAL_W'(1)) : fin.q;
            K_REM:   res = fin.negr ? (~fin.rm + VAL_W'(1)) : fin.rm;
            default: res = fin.res;
        endcase
        n_out_data.result_defined = fin.def;
        n_out_data.result         = fin.def ? (res & fin.omask) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= w_vld[DATA_WIDTH];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

    `PALU_ASSERT_IMPL(a_stall_blocks_input, i_clk, i_rst_n, o_valid && !i_ready, !o_ready, "ready while held")
    `PALU_ASSERT_IMPL(a_undef_is_zero, i_clk, i_rst_n, o_valid && !o_data.result_defined, o_data.result == '0, "undef not zero")
    `PALU_ASSERT(a_last_stage_to_out, i_clk, i_rst_n, en && w_vld[DATA_WIDTH] |=> o_valid, "result lost")
    `PALU_ASSERT(a_hold_while_stalled, i_clk, i_rst_n, o_valid && !i_ready |=> o_valid && $stable(o_data), "held output changed")

endmodule
`default_nettype wire

>>> rtl/core/palu_front.sv
// Front stages of the ALU core: operand prep, operation decode and multiply.
// Depends on palu_pkg.
`default_nettype none
module palu_front
    import palu_pkg::*;
#(
    parameter int unsigned DATA_WIDTH = 64
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_en,
    input  wire logic     i_valid,
    input  wire t_in_item i_data,
    output logic          o_valid,
    output t_pipe         o_pipe
);

    localparam logic [VAL_W-1:0] DMASK = {VAL_W{1'b1}} >> (VAL_W - DATA_WIDTH);
    localparam logic [6:0]       CAP   = 7'(DATA_WIDTH);
    localparam logic [VAL_W-1:0] W_VAL = VAL_W'(DATA_WIDTH);
    localparam logic [VAL_W-1:0] W_BYT = VAL_W'(DATA_WIDTH / 8);

    typedef struct packed {
        logic [4:0]       func;
        logic             ad;
        logic             bd;
        logic [VAL_W-1:0] a;
        logic [VAL_W-1:0] b;
        logic [VAL_W-1:0] x;
        logic [VAL_W-1:0] y;
        logic [VAL_W-1:0] amask;
        logic [VAL_W-1:0] bmask;
        logic [6:0]       bbits;
        logic [VAL_W-1:0] omask;
        logic             b_lt_w;
        logic             b_lt_byt;
    } t_s1;

    typedef struct packed {
        t_pipe       p;
        logic        is_mul;
        logic [63:0] p0;
        logic [31:0] p1;
        logic [31:0] p2;
    } t_s2;

    function automatic logic [6:0] size_bits(input logic [3:0] by);
        logic [6:0] bits;
        if (by >= 4'd1 && by <= 4'd8) begin
            bits = {by[3:0], 3'b000};
        end else begin
            bits = 7'd64;
        end
        if (bits > CAP) begin
            bits = CAP;
        end
        return bits;
    endfunction

    function automatic logic [VAL_W-1:0] low_mask(input logic [6:0] bits);
        if (bits >= 7'd64) begin
            return {VAL_W{1'b1}};
        end
        return (VAL_W'(1) << bits[5:0]) - VAL_W'(1);
    endfunction

    logic            r_v1, r_v2, r_v3;
    t_s1             r_s1, n_s1;
    t_s2             r_s2, n_s2;
    t_pipe           r_s3, n_s3;

    logic [6:0]       abits, bbits;
    logic [5:0]       sidx;
    logic [VAL_W-1:0] a_in, b_in, am;

    always_comb begin
        a_in  = i_data.a_value & DMASK;
        b_in  = i_data.b_value & DMASK;
        abits = size_bits(i_data.a_bytes);
        bbits = size_bits(i_data.b_bytes);
        am    = low_mask(abits);
        sidx  = 6'(abits - 7'd1);
        n_s1.func     = i_data.func;
        n_s1.ad       = i_data.a_defined;
        n_s1.bd       = i_data.b_defined;
        n_s1.a        = a_in;
        n_s1.b        = b_in;
        n_s1.x        = a_in[sidx] ? (a_in | ~am) : (a_in & am);
        n_s1.y        = b_in[sidx] ? (b_in | ~am) : (b_in & am);
        n_s1.amask    = am;
        n_s1.bmask    = low_mask(bbits);
        n_s1.bbits    = bbits;
        n_s1.omask    = ((i_data.out_bytes != 4'd0) ? low_mask(size_bits(i_data.out_bytes))
                                                     : {VAL_W{1'b1}}) & DMASK;
        n_s1.b_lt_w   = b_in < W_VAL;
        n_s1.b_lt_byt = b_in < W_BYT;
    end

    logic             both, nx, ny;
    logic [VAL_W-1:0] ux, uy;
    logic [31:0]      al, ah, bl, bh;

    always_comb begin
        both = r_s1.ad && r_s1.bd;
        nx   = r_s1.x[VAL_W-1];
        ny   = r_s1.y[VAL_W-1];
        ux   = nx ? (~r_s1.x + VAL_W'(1)) : r_s1.x;
        uy   = ny ? (~r_s1.y + VAL_W'(1)) : r_s1.y;
        al   = r_s1.a[31:0];
        ah   = r_s1.a[63:32];
        bl   = r_s1.b[31:0];
        bh   = r_s1.b[63:32];
        n_s2.p.kind  = K_SIMPLE;
        n_s2.p.def   = 1'b0;
        n_s2.p.negr  = 1'b0;
        n_s2.p.res   = '0;
        n_s2.p.omask = r_s1.omask;
        n_s2.p.dd    = r_s1.a;
        n_s2.p.dv    = r_s1.b;
        n_s2.p.q     = '0;
        n_s2.p.rm    = '0;
        n_s2.is_mul  = 1'b0;
        n_s2.p0      = al * bl;
        n_s2.p1      = al * bh;
        n_s2.p2      = ah * bl;
        case (t_op'(r_s1.func))
            OP_COPY: begin
                n_s2.p.def = r_s1.ad;
                n_s2.p.res = r_s1.a;
            end
            OP_EQ: begin
                n_s2.p.def = both;
                n_s2.p.res = VAL_W'(r_s1.a == r_s1.b);
            end
            OP_NE: begin
                n_s2.p.def = both;
                n_s2.p.res = VAL_W'(r_s1.a != r_s1.b);
            end
            OP_LTU: begin
                n_s2.p.def = both;
                n_s2.p.res = VAL_W'(r_s1.a < r_s1.b);
            end
            OP_LTS: begin
                n_s2.p.def = both;
                n_s2.p.res = VAL_W'($signed(r_s1.x) < $signed(r_s1.y));
            end
            OP_LEU: begin
                n_s2.p.def = both;
                n_s2.p.res = VAL_W'(r_s1.a <= r_s1.b);
            end
            OP_LES: begin
                n_s2.p.def = both;
                n_s2.p.res = VAL_W'($signed(r_s1.x) <= $signed(r_s1.y));
            end
            OP_ZEXT: begin
                n_s2.p.def = r_s1.ad;
                n_s2.p.res = r_s1.a & r_s1.amask;
            end
            OP_SEXT: begin
                n_s2.p.def = r_s1.ad;
                n_s2.p.res = r_s1.x;
            end
            OP_ADD: begin
                n_s2.p.def = both;
                n_s2.p.res = r_s1.a + r_s1.b;
            end
            OP_SUB: begin
                n_s2.p.def = both;
                n_s2.p.res = r_s1.a - r_s1.b;
            end
            OP_NOT: begin
                n_s2.p.def = r_s1.ad;
                n_s2.p.res = ~r_s1.a;
            end
            OP_XOR: begin
                n_s2.p.def = both;
                n_s2.p.res = r_s1.a ^ r_s1.b;
            end
            OP_AND: begin
                n_s2.p.def = both;
                n_s2.p.res = r_s1.a & r_s1.b;
            end
            OP_OR: begin
                n_s2.p.def = both;
                n_s2.p.res = r_s1.a | r_s1.b;
            end
            OP_SHL: begin
                n_s2.p.def = both;
                n_s2.p.res = r_s1.b_lt_w ? (r_s1.a << r_s1.b[5:0]) : '0;
            end
            OP_SHR: begin
                n_s2.p.def = both;
                n_s2.p.res = r_s1.b_lt_w ? (r_s1.a >> r_s1.b[5:0]) : '0;
            end
            OP_SAR: begin
                n_s2.p.def = both;
                n_s2.p.res = r_s1.b_lt_w ? VAL_W'($signed(r_s1.x) >>> r_s1.b[5:0]) : '0;
            end
            OP_MUL: begin
                n_s2.p.def  = both;
                n_s2.is_mul = 1'b1;
            end
            OP_DIVU: begin
                n_s2.p.def  = both && (r_s1.b != '0);
                n_s2.p.kind = K_DIV;
            end
            OP_REMU: begin
                n_s2.p.def  = both && (r_s1.b != '0);
                n_s2.p.kind = K_REM;
            end
            OP_DIVS: begin
                n_s2.p.def  = both && (r_s1.y != '0);
                n_s2.p.kind = K_DIV;
                n_s2.p.dd   = ux;
                n_s2.p.dv   = uy;
                n_s2.p.negr = nx ^ ny;
            end
            OP_REMS: begin
                n_s2.p.def  = both && (r_s1.y != '0);
                n_s2.p.kind = K_REM;
                n_s2.p.dd   = ux;
                n_s2.p.dv   = uy;
                n_s2.p.negr = nx;
            end
            OP_BNOT: begin
                n_s2.p.def = r_s1.ad;
                n_s2.p.res = VAL_W'(r_s1.a == '0);
            end
            OP_BXOR: begin
                n_s2.p.def = both;
                n_s2.p.res = VAL_W'((r_s1.a != '0) != (r_s1.b != '0));
            end
            OP_BAND: begin
                n_s2.p.def = both;
                n_s2.p.res = VAL_W'((r_s1.a != '0) && (r_s1.b != '0));
            end
            OP_BOR: begin
                n_s2.p.def = both;
                n_s2.p.res = VAL_W'((r_s1.a != '0) || (r_s1.b != '0));
            end
            OP_PIECE: begin
                n_s2.p.def = both;
                n_s2.p.res = (r_s1.a << r_s1.bbits) | (r_s1.b & r_s1.bmask);
            end
            OP_SUBPIECE: begin
                n_s2.p.def = both;
                n_s2.p.res = r_s1.b_lt_byt ?
                    ((r_s1.a & r_s1.amask) >> {r_s1.b[2:0], 3'b000}) : '0;
            end
            default: begin
                n_s2.p.def = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_s3 = r_s2.p;
        if (r_s2.is_mul) begin
            n_s3.res = r_s2.p0 + {r_s2.p1 + r_s2.p2, 32'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1 <= n_s1;
            r_s2 <= n_s2;
            r_s3 <= n_s3;
        end
    end

    assign o_valid = r_v3;
    assign o_pipe  = r_s3;

endmodule
`default_nettype wire

>>> rtl/core/palu_div_step.sv
// One restoring-division stage: resolves a single quotient bit per register stage.
// Depends on palu_pkg.
`default_nettype none
module palu_div_step
    import palu_pkg::*;
#(
    parameter int unsigned BIT = 0
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_en,
    input  wire logic  i_valid,
    input  wire t_pipe i_pipe,
    output logic       o_valid,
    output t_pipe      o_pipe
);

    logic         r_valid;
    t_pipe        r_pipe, n_pipe;
    logic [VAL_W:0] trial, diff;
    logic           ge;

    always_comb begin
        trial = {i_pipe.rm, i_pipe.dd[BIT]};
        diff  = trial - {1'b0, i_pipe.dv};
        ge    = trial >= {1'b0, i_pipe.dv};
        n_pipe        = i_pipe;
        n_pipe.rm     = ge ? diff[VAL_W-1:0] : trial[VAL_W-1:0];
        n_pipe.q[BIT] = ge;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pipe <= n_pipe;
        end
    end

    assign o_valid = r_valid;
    assign o_pipe  = r_pipe;

endmodule
`default_nettype wire
